FILE: rtl/b64e_pkg.sv
// Shared types, constants and the Base64 alphabet lookup for the stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

  // Reset value of the pad character register ('=').
  localparam logic [7:0] PAD_RESET = 8'd61;

  // Default number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Beat on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Beat on the output channel.
  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       stream_end;
  } out_beat_t;

  // Work for one input byte: up to two sextets, then pad characters.
  // count_m1 is the number of characters minus one.
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic [1:0] count_m1;
    logic       last;
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return 8'd65 + v8;
    end else if (v < 6'd52) begin
      return 8'd71 + v8;
    end else if (v < 6'd62) begin
      return v8 - 8'd4;
    end else if (v == 6'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

endpackage

FILE: rtl/b64e_front.sv
// Front end: accepts input bytes, tracks the group position and builds one job per byte.
`timescale 1ns / 1ps

module b64e_front
  import b64e_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     queue_full,
  output logic     push,
  output job_t     job
);

  logic [1:0] group_pos;
  logic [1:0] group_pos_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;
  logic [7:0] b;

  assign b        = in_data.data_byte;
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Split the byte into sextets according to its place in the group.
  always_comb begin
    job.last = in_data.last_byte;
    case (group_pos)
      2'd1: begin
        job.sext0      = {leftover[1:0], b[7:4]};
        job.sext1      = {b[3:0], 2'b00};
        job.count_m1   = in_data.last_byte ? 2'd2 : 2'd0;
        leftover_next  = b[3:0];
        group_pos_next = 2'd2;
      end
      2'd2: begin
        job.sext0      = {leftover, b[7:6]};
        job.sext1      = b[5:0];
        job.count_m1   = 2'd1;
        leftover_next  = 4'd0;
        group_pos_next = 2'd0;
      end
      default: begin
        job.sext0      = b[7:2];
        job.sext1      = {b[1:0], 4'b0000};
        job.count_m1   = in_data.last_byte ? 2'd3 : 2'd0;
        leftover_next  = {2'b00, b[1:0]};
        group_pos_next = 2'd1;
      end
    endcase
  end

  // Group state advances on every accepted beat; a last byte starts a new stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= 2'd0;
      leftover  <= 4'd0;
    end else if (push) begin
      if (in_data.last_byte) begin
        group_pos <= 2'd0;
        leftover  <= 4'd0;
      end else begin
        group_pos <= group_pos_next;
        leftover  <= leftover_next;
      end
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
// Small first-in first-out queue of jobs between the front and back ends.
`timescale 1ns / 1ps

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
// Back end: expands queued jobs into characters and holds the output register.
`timescale 1ns / 1ps

module b64e_back
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data,
  input  job_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic [7:0] pad_symbol;
  logic [1:0] idx;
  logic       load;
  logic       emit;
  logic       last_char;
  logic [7:0] next_char;

  assign cfg_ready = 1'b1;

  assign load      = !out_valid || !out_stall;
  assign emit      = head_valid && load;
  assign last_char = (idx == head.count_m1);
  assign pop       = emit && last_char;

  // The first two characters come from sextets, the rest are pads.
  always_comb begin
    case (idx)
      2'd0:    next_char = sextet_char(head.sext0);
      2'd1:    next_char = sextet_char(head.sext1);
      default: next_char = pad_symbol;
    endcase
  end

  // Pad register; user must write only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_symbol <= PAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pad_symbol <= cfg_data;
    end
  end

  // Character index within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (emit) begin
      idx <= last_char ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register: refills whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.code_char  <= next_char;
      out_data.run_end    <= last_char;
      out_data.stream_end <= last_char && head.last;
    end
  end

  // The index never runs past the character count of the job at the head.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.count_m1)
    else $error("character index beyond job length");

  // Finishing a job always leaves its last character in the output register.
  a_pop_shows_run_end: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && out_data.run_end)
    else $error("job retired without run end beat");

  // The end of the stream is always the end of a run.
  a_stream_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_end |-> out_data.run_end)
    else $error("stream end without run end");

  // A new job starts at its first character.
  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 2'd0)
    else $error("index not cleared after job");

endmodule

FILE: rtl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, job queue and back end.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid / in_stall / in_data) takes one raw byte per beat,
// with last_byte marking the end of a stream. Output channel (out_valid /
// out_stall / out_data) gives one character per beat, with run_end on the
// last character caused by a byte and stream_end on the final character.
// A byte at group position 0 or 1 yields one character, or four / three when
// it is last; a byte completing a group yields two.
// The first character of an accepted byte passes through the job queue and
// then the output register, when the output register and queue are empty.
// Throughput: one byte per cycle in while the queue is not full, and one
// character per cycle out while out_stall is low; the output port sets the
// sustained rate, and the queue absorbs bursts so bytes flow until it fills.
// The pad character register is written through cfg_valid / cfg_ready /
// cfg_data, which is always ready; write it only while the block is idle.
// Reset clears the group state, the queue and the output register, and sets
// the pad character to '='. When the receiver stalls, the output beat holds,
// the queue fills, and in_stall rises once the queue is full.

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data
);

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (queue_full),
    .empty  (queue_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head       (head_job),
    .head_valid (!queue_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: dv/b64e_checker.sv
// Checker that predicts the encoder's character beats and compares them with the output channel.
`timescale 1ns / 1ps

module b64e_checker
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_beat_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_beat_t  out_data,
  output int         err_count,
  output int         pending
);

  // Standard alphabet, first character in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predicted encoder state and pad register.
  logic [7:0] pad_char;
  logic [1:0] grp_pos;
  logic [3:0] carry_bits;

  // Character beats predicted but not yet seen on the output channel.
  out_beat_t char_queue[$];

  initial begin
    err_count = 0;
    pending = 0;
    pad_char = PAD_RESET;
    grp_pos = 2'd0;
    carry_bits = 4'd0;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return ALPHABET[8*(63 - v) +: 8];
  endfunction

  // Works out the characters that one input byte causes and queues them.
  task automatic encode_byte(input in_beat_t beat);
    logic [7:0] chars [4];
    logic [7:0] d;
    int n;
    out_beat_t ob;
    d = beat.data_byte;
    if (grp_pos == 2'd1) begin
      chars[0] = b64_char({carry_bits[1:0], d[7:4]});
      chars[1] = b64_char({d[3:0], 2'b00});
      chars[2] = pad_char;
      n = beat.last_byte ? 3 : 1;
      carry_bits = d[3:0];
      grp_pos = 2'd2;
    end else if (grp_pos == 2'd2) begin
      chars[0] = b64_char({carry_bits, d[7:6]});
      chars[1] = b64_char(d[5:0]);
      n = 2;
      carry_bits = 4'd0;
      grp_pos = 2'd0;
    end else begin
      // Position zero; an impossible position three is handled the same way.
      chars[0] = b64_char(d[7:2]);
      chars[1] = b64_char({d[1:0], 4'b0000});
      chars[2] = pad_char;
      chars[3] = pad_char;
      n = beat.last_byte ? 4 : 1;
      carry_bits = {2'b00, d[1:0]};
      grp_pos = 2'd1;
    end
    // A last byte closes the stream and returns the group state to reset.
    if (beat.last_byte) begin
      grp_pos = 2'd0;
      carry_bits = 4'd0;
    end
    for (int i = 0; i < n; i++) begin
      ob.code_char = chars[i];
      ob.run_end = (i == n - 1);
      ob.stream_end = beat.last_byte && (i == n - 1);
      char_queue.push_back(ob);
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // Watch all three channels at each edge.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      pad_char = PAD_RESET;
      grp_pos = 2'd0;
      carry_bits = 4'd0;
      char_queue.delete();
    end else begin
      // An output beat is checked before the input beat of the same edge is predicted.
      if (out_valid && !out_stall) begin
        if (char_queue.size() == 0) begin
          note_error($sformatf("unexpected beat char=%02h run_end=%0b stream_end=%0b",
                               out_data.code_char, out_data.run_end, out_data.stream_end));
        end else begin
          want = char_queue.pop_front();
          if (out_data !== want) begin
            note_error($sformatf(
              "expected char=%02h run_end=%0b stream_end=%0b, got char=%02h run_end=%0b stream_end=%0b",
              want.code_char, want.run_end, want.stream_end,
              out_data.code_char, out_data.run_end, out_data.stream_end));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        pad_char = cfg_data;
      end
      if (in_valid && !in_stall) begin
        encode_byte(in_data);
      end
    end
    pending <= char_queue.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the Base64 stream encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import b64e_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 22;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;

  int err_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  base64_stream_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  b64e_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("base64_stream_encoder test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked > holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one byte beat, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_byte(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {d, last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Waits until every predicted character has come out.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_pad(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random streams of mostly short length under one idling mix, then a full drain.
  task automatic run_phase(input int idle, input int stall, input int n_items);
    int sent;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(7, 1);
      send_stream(len);
      sent += len;
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset pad character: single-byte, two-byte and
    // three-byte streams, extreme byte values, and a group that yields '+' and '/'.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own pad character and idling mix.
    write_pad(8'h00);
    run_phase(0, 0, PHASE_ITEMS);
    write_pad(8'hFF);
    run_phase(83, 0, PHASE_ITEMS);
    write_pad(8'($urandom_range(255)));
    holds_asked++;
    run_phase(0, 83, PHASE_ITEMS);
    write_pad(PAD_RESET);
    run_phase(7, 7, PHASE_ITEMS);

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("base64_stream_encoder test passed");
    end else begin
      $display("base64_stream_encoder test failed");
    end
    $finish;
  end

endmodule
